[rtl/core/cpcc_pkg.sv]
package cpcc_pkg;

    // CRC-16/CCITT-FALSE
    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [15:0] CRC_INIT = 16'hFFFF;

    // Packet layout
    localparam logic [15:0] LEN_NONE      = 16'hFFFF;
    localparam logic [16:0] COUNT_MAX     = 17'h1FFFF;
    localparam logic [16:0] MIN_TOTAL     = 17'd8;
    localparam logic [16:0] HDR_BYTES     = 17'd6;
    localparam logic [16:0] TRAILER_BYTES = 17'd2;

    // Header byte positions
    localparam logic [16:0] POS_APID_HI = 17'd0;
    localparam logic [16:0] POS_APID_LO = 17'd1;
    localparam logic [16:0] POS_LEN_HI  = 17'd4;
    localparam logic [16:0] POS_LEN_LO  = 17'd5;

    // Verdict codes
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_TOO_SHORT = 2'd1,
        ST_LEN_ERR   = 2'd2,
        ST_CRC_ERR   = 2'd3
    } t_status;

    // One result item
    typedef struct packed {
        logic [15:0] crc_received;
        logic [15:0] crc_computed;
        logic [16:0] payload_length;
        logic [10:0] apid;
        t_status     status;
    } t_result;

endpackage

[rtl/core/cpcc_crc_byte.sv]
module cpcc_crc_byte (
    input  logic [15:0] i_crc,
    input  logic [7:0]  i_byte,
    output logic [15:0] o_crc
);
    import cpcc_pkg::*;

    // Bytewise CRC update, MSB first, eight shift steps
    always_comb begin
        logic [15:0] v_crc;
        v_crc = i_crc ^ {i_byte, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (v_crc[15]) begin
                v_crc = {v_crc[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                v_crc = {v_crc[14:0], 1'b0};
            end
        end
        o_crc = v_crc;
    end

endmodule

[rtl/core/ccsds_packet_crc_checker.sv]
// A packet's last byte passes the input register, then its verdict is registered in the output register.
// Throughput: one byte per cycle; non-final bytes keep flowing while a verdict waits,
// a final byte holds in the input stage until the previous verdict is taken.
// Reset (i_rst_n low, synchronous): packet state cleared, CRC set to 0xFFFF,
// both stages emptied.
module ccsds_packet_crc_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tlast,   // last_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata    // [1:0] status, [12:2] apid, [29:13] payload_length,
                                        // [45:30] crc_computed, [61:46] crc_received, zeros
);
    import cpcc_pkg::*;

    // Input stage
    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic        r_in_last;

    // Packet state
    logic [16:0] r_count, n_count;
    logic [10:0] r_apid, n_apid;
    logic [15:0] r_len, n_len;
    logic [15:0] r_crc, n_crc;
    logic [15:0] r_tail, n_tail;

    // Output register
    logic        r_out_valid;
    t_result     r_out, n_out;

    logic        out_free;
    logic        s1_go;
    logic [15:0] crc_fed;
    logic [16:0] plen;

    // Stage 1 moves on unless it holds a last byte and the output is busy
    assign out_free      = !r_out_valid || m_axis_tready;
    assign s1_go         = r_in_valid && (!r_in_last || out_free);
    assign s_axis_tready = !r_in_valid || s1_go;

    cpcc_crc_byte u_crc (
        .i_crc  (r_crc),
        .i_byte (r_tail[15:8]),
        .o_crc  (crc_fed)
    );

    // Next packet state and verdict for the byte in stage 1
    always_comb begin
        n_crc  = (r_count >= TRAILER_BYTES) ? crc_fed : r_crc;
        n_tail = {r_tail[7:0], r_in_byte};
        n_apid = r_apid;
        n_len  = r_len;
        if (r_count == POS_APID_HI) begin
            n_apid = {r_in_byte[2:0], r_apid[7:0]};
        end else if (r_count == POS_APID_LO) begin
            n_apid = {r_apid[10:8], r_in_byte};
        end else if (r_count == POS_LEN_HI) begin
            n_len = {r_in_byte, r_len[7:0]};
        end else if (r_count == POS_LEN_LO) begin
            n_len = {r_len[15:8], r_in_byte};
        end
        n_count = (r_count != COUNT_MAX) ? r_count + 17'd1 : r_count;

        plen = (n_len == LEN_NONE) ? 17'd0 : {1'b0, n_len} + 17'd1;

        n_out = '0;
        if (n_count < MIN_TOTAL) begin
            n_out.status = ST_TOO_SHORT;
        end else begin
            if (n_count != plen + HDR_BYTES + TRAILER_BYTES) begin
                n_out.status = ST_LEN_ERR;
            end else if (n_crc != n_tail) begin
                n_out.status = ST_CRC_ERR;
            end else begin
                n_out.status = ST_OK;
            end
            n_out.apid           = n_apid;
            n_out.payload_length = plen;
            n_out.crc_computed   = n_crc;
            n_out.crc_received   = n_tail;
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_byte <= s_axis_tdata;
            r_in_last <= s_axis_tlast;
        end
    end

    // Packet state, cleared after each last byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_apid  <= '0;
            r_len   <= '0;
            r_crc   <= CRC_INIT;
            r_tail  <= '0;
        end else if (s1_go) begin
            if (r_in_last) begin
                r_count <= '0;
                r_apid  <= '0;
                r_len   <= '0;
                r_crc   <= CRC_INIT;
                r_tail  <= '0;
            end else begin
                r_count <= n_count;
                r_apid  <= n_apid;
                r_len   <= n_len;
                r_crc   <= n_crc;
                r_tail  <= n_tail;
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= s1_go && r_in_last;
        end
        if (out_free && s1_go && r_in_last) begin
            r_out <= n_out;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {2'b00, r_out};

endmodule

[dv/ccsds_packet_crc_checker_tb.sv]
module ccsds_packet_crc_checker_tb;
    import cpcc_pkg::*;

    localparam int IDLE_LIMIT  = 4000;  // cycles with no item moving on either side
    localparam int PHASE_ITEMS = 225;   // bytes per random phase
    localparam int DRAIN_TAIL  = 10;    // cycles after the last verdict
    localparam int MAX_REPORTS = 10;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;   // [7:0] data_byte
    logic        s_axis_tlast;   // last_byte
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [63:0] m_axis_tdata;   // [1:0] status, [12:2] apid, [29:13] payload_length,
                                 // [45:30] crc_computed, [61:46] crc_received, zeros

    ccsds_packet_crc_checker dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Packet state of the predictor, at its reset values
    logic [16:0] rx_count     = '0;
    logic [10:0] rx_apid      = '0;
    logic [15:0] rx_len_field = '0;
    logic [15:0] rx_crc       = CRC_INIT;
    logic [15:0] rx_tail      = '0;

    t_result verdict_q[$];
    int unsigned mismatches  = 0;
    int unsigned bytes_sent  = 0;
    int unsigned idle_cycles = 0;
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // CRC-16/CCITT-FALSE, one byte, MSB first
    function automatic logic [15:0] crc16_ccitt_byte(input logic [15:0] crc,
                                                     input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

    // Advance the packet state by one byte; returns 1 with the verdict on the last byte
    function automatic bit predict_verdict(input logic [7:0] b, input bit is_last,
                                           output t_result v);
        logic [16:0] pos;
        logic [16:0] plen;
        pos = rx_count;
        v   = '0;
        // bytes leave the two-byte delay line into the CRC
        if (pos >= TRAILER_BYTES) begin
            rx_crc = crc16_ccitt_byte(rx_crc, rx_tail[15:8]);
        end
        rx_tail = {rx_tail[7:0], b};
        case (pos)
            POS_APID_HI: rx_apid[10:8]     = b[2:0];
            POS_APID_LO: rx_apid[7:0]      = b;
            POS_LEN_HI:  rx_len_field[15:8] = b;
            POS_LEN_LO:  rx_len_field[7:0]  = b;
            default: ;
        endcase
        if (rx_count != COUNT_MAX) begin
            rx_count = rx_count + 17'd1;
        end
        if (!is_last) begin
            return 1'b0;
        end
        plen = (rx_len_field == LEN_NONE) ? 17'd0 : {1'b0, rx_len_field} + 17'd1;
        if (rx_count < MIN_TOTAL) begin
            v.status = ST_TOO_SHORT;
        end else begin
            if (rx_count != HDR_BYTES + plen + TRAILER_BYTES) begin
                v.status = ST_LEN_ERR;
            end else if (rx_crc != rx_tail) begin
                v.status = ST_CRC_ERR;
            end else begin
                v.status = ST_OK;
            end
            v.apid           = rx_apid;
            v.payload_length = plen;
            v.crc_computed   = rx_crc;
            v.crc_received   = rx_tail;
        end
        // back to the reset state for the next packet
        rx_count     = '0;
        rx_apid      = '0;
        rx_len_field = '0;
        rx_crc       = CRC_INIT;
        rx_tail      = '0;
        return 1'b1;
    endfunction

    // Send one item, wait for it to be taken, then predict
    task automatic send_byte(input logic [7:0] b, input bit is_last);
        t_result v;
        while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= is_last;
        do @(posedge i_clk); while (!s_axis_tready);
        bytes_sent++;
        if (predict_verdict(b, is_last, v)) begin
            verdict_q.push_back(v);
        end
    endtask

    // Random bytes with only the final one marked
    task automatic send_raw(input int unsigned n);
        for (int unsigned i = 0; i < n; i++) begin
            send_byte(8'($urandom), i == n - 1);
        end
    endtask

    // Header, payload and CRC trailer; the trailer can be damaged on purpose
    task automatic send_packet(input logic [10:0] apid, input logic [15:0] len_field,
                               input int unsigned payload_n, input bit bad_crc);
        logic [7:0]  pkt[$];
        logic [15:0] crc;
        pkt.push_back({5'($urandom), apid[10:8]});
        pkt.push_back(apid[7:0]);
        pkt.push_back(8'($urandom));
        pkt.push_back(8'($urandom));
        pkt.push_back(len_field[15:8]);
        pkt.push_back(len_field[7:0]);
        for (int unsigned i = 0; i < payload_n; i++) begin
            pkt.push_back(8'($urandom));
        end
        crc = CRC_INIT;
        foreach (pkt[i]) begin
            crc = crc16_ccitt_byte(crc, pkt[i]);
        end
        if (bad_crc) begin
            crc = crc ^ (16'd1 << $urandom_range(0, 15));
        end
        pkt.push_back(crc[15:8]);
        pkt.push_back(crc[7:0]);
        foreach (pkt[i]) begin
            send_byte(pkt[i], i == pkt.size() - 1);
        end
    endtask

    // Hold the sender until every verdict has come out
    task automatic wait_verdicts_drained();
        s_axis_tvalid <= 1'b0;
        while (verdict_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] got_v);
        if (exp_v !== got_v) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS) begin
                $display("mismatch %s: expected %0h, got %0h", name, exp_v, got_v);
            end
        end
    endtask

    // Short packets, header field extremes
    task automatic test_directed_extremes();
        send_raw(1);
        send_raw(7);
        send_packet(11'h7FF, LEN_NONE, 0, 1'b0);   // zero payload, good CRC
        send_packet(11'h000, 16'hFFFE, 0, 1'b0);   // largest length field, far too few bytes
    endtask

    // Mostly well-formed packets, plus damaged ones and noise
    task automatic test_random_traffic(input int unsigned idle_pct, input int unsigned stall_pct);
        int unsigned start;
        int unsigned sel;
        int unsigned len;
        int unsigned n;
        logic [15:0] field;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        start = bytes_sent;
        while (bytes_sent - start < PHASE_ITEMS) begin
            sel   = $urandom_range(0, 99);
            len   = $urandom_range(0, 15);
            field = 16'(len);
            if (sel < 60) begin
                if ($urandom_range(0, 9) == 0) begin
                    send_packet(11'($urandom), LEN_NONE, 0, 1'b0);
                end else begin
                    send_packet(11'($urandom), field, len + 1, 1'b0);
                end
            end else if (sel < 72) begin
                send_packet(11'($urandom), field, len + 1, 1'b1);
            end else if (sel < 82) begin
                // payload count off by a few bytes, or an absurd length field
                if ($urandom_range(0, 3) == 0) begin
                    field = 16'($urandom_range(16'h8000, 16'hFFFE));
                    n     = len;
                end else begin
                    n = len + 1 + $urandom_range(1, 3);
                    if ($urandom_range(0, 1) == 0 && len >= 3) begin
                        n = len + 1 - $urandom_range(1, 3);
                    end
                end
                send_packet(11'($urandom), field, n, 1'($urandom_range(0, 1)));
            end else if (sel < 90) begin
                send_raw($urandom_range(1, 7));
            end else begin
                send_raw($urandom_range(1, 30));
            end
        end
    endtask

    // Result side: check each verdict, then choose the next ready value
    always @(posedge i_clk) begin : verdict_check
        t_result got;
        t_result exp_v;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = t_result'(m_axis_tdata[61:0]);
            if (verdict_q.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS) begin
                    $display("unexpected verdict: got %0h", m_axis_tdata);
                end
            end else begin
                exp_v = verdict_q.pop_front();
                check_field("status", 32'(exp_v.status), 32'(got.status));
                check_field("apid", 32'(exp_v.apid), 32'(got.apid));
                check_field("payload_length", 32'(exp_v.payload_length),
                            32'(got.payload_length));
                check_field("crc_computed", 32'(exp_v.crc_computed), 32'(got.crc_computed));
                check_field("crc_received", 32'(exp_v.crc_received), 32'(got.crc_received));
            end
        end
        m_axis_tready <= (recv_stall_pct == 0) || ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Watchdog: nothing moving on either side for too long
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles == IDLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Test sequence
    initial begin
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tlast  <= 1'b0;
        m_axis_tready <= 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_extremes();
        wait_verdicts_drained();
        test_random_traffic(0, 0);
        test_random_traffic(74, 0);
        wait_verdicts_drained();
        test_random_traffic(0, 74);
        test_random_traffic(25, 25);

        // drain, then allow the pipeline to show any stray verdict
        wait_verdicts_drained();
        recv_stall_pct = 0;
        repeat (DRAIN_TAIL) @(posedge i_clk);
        if (mismatches == 0 && verdict_q.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

[files.f]
rtl/core/cpcc_pkg.sv
rtl/core/cpcc_crc_byte.sv
rtl/core/ccsds_packet_crc_checker.sv
dv/ccsds_packet_crc_checker_tb.sv
